[rtl/tekd_pkg.sv]
// package: types, codes and key table of the terminal escape key decoder
`timescale 1ns / 1ps
package tekd_pkg;

  localparam int SeqMaxLenDefault = 8;
  localparam logic [15:0] TimeoutReset = 16'd100;
  localparam logic [7:0] EscByte = 8'd27;
  localparam logic [16:0] TickMax = 17'h1ffff;
  localparam int TableSize = 122;
  localparam int BaseEntries = 54;
  localparam int EntryLen = 6;

  localparam logic [2:0] StPlain = 3'd0;
  localparam logic [2:0] StPending = 3'd1;
  localparam logic [2:0] StKey = 3'd2;
  localparam logic [2:0] StUnknown = 3'd3;
  localparam logic [2:0] StBareEsc = 3'd4;
  localparam logic [2:0] StNothing = 3'd5;

  localparam logic RegTimeout = 1'b0;
  localparam logic RegFkeys = 1'b1;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] char_out;
    logic [6:0] key_code;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  char_out;
    logic        do_match;
    logic        fkeys;
    logic [3:0]  len;
    logic [47:0] bytes;
  } job_t;

  typedef struct packed {
    logic [3:0]  len;
    logic [47:0] text;
    logic [6:0]  key;
  } entry_t;

  function automatic entry_t mk(input string s, input int k);
    entry_t e;
    e.len = 4'(s.len());
    e.text = '0;
    e.key = 7'(k);
    for (int i = 0; i < EntryLen; i++) begin
      if (i < s.len()) e.text[8*i +: 8] = s[i];
    end
    return e;
  endfunction

  function automatic entry_t table_row(input int idx);
    entry_t e;
    e = '0;
    case (idx)
      0: e = mk("[A", 0); 1: e = mk("[B", 1); 2: e = mk("[C", 2); 3: e = mk("[D", 3);
      4: e = mk("[E", 4); 5: e = mk("[F", 5); 6: e = mk("[G", 4); 7: e = mk("[H", 6);
      8: e = mk("[1~", 6); 9: e = mk("[2~", 7); 10: e = mk("[3~", 8); 11: e = mk("[4~", 5);
      12: e = mk("[5~", 9); 13: e = mk("[6~", 10); 14: e = mk("OF", 5); 15: e = mk("OH", 6);
      16: e = mk("[1;2A", 11); 17: e = mk("[1;2B", 12); 18: e = mk("[1;2C", 13);
      19: e = mk("[1;2D", 14); 20: e = mk("[1;2E", 15); 21: e = mk("[1;2F", 16);
      22: e = mk("[1;2H", 17); 23: e = mk("[3;2~", 18);
      24: e = mk("[2;5A", 11); 25: e = mk("[2;5B", 12); 26: e = mk("[2;5C", 13);
      27: e = mk("[2;5D", 14);
      28: e = mk("[1;3A", 19); 29: e = mk("[1;3B", 20); 30: e = mk("[1;3C", 21);
      31: e = mk("[1;3D", 22); 32: e = mk("[1;3E", 23); 33: e = mk("[1;3F", 24);
      34: e = mk("[1;3H", 25); 35: e = mk("[5;3~", 26); 36: e = mk("[6;3~", 27);
      37: e = mk("[3;5A", 19); 38: e = mk("[3;5B", 20); 39: e = mk("[3;5C", 21);
      40: e = mk("[3;5D", 22);
      41: e = mk("[1;5A", 28); 42: e = mk("[1;5B", 29); 43: e = mk("[1;5C", 30);
      44: e = mk("[1;5D", 31); 45: e = mk("[1;5E", 32); 46: e = mk("[1;5F", 33);
      47: e = mk("[1;5H", 34); 48: e = mk("[5;5~", 35); 49: e = mk("[6;5~", 36);
      50: e = mk("OA", 28); 51: e = mk("OB", 29); 52: e = mk("OC", 30); 53: e = mk("OD", 31);
      54: e = mk("[11~", 37); 55: e = mk("[12~", 38); 56: e = mk("[13~", 39);
      57: e = mk("[14~", 40); 58: e = mk("[15~", 41); 59: e = mk("[17~", 42);
      60: e = mk("[18~", 43); 61: e = mk("[19~", 44); 62: e = mk("[20~", 45);
      63: e = mk("[21~", 46); 64: e = mk("[23~", 47); 65: e = mk("[24~", 48);
      66: e = mk("[1P", 37); 67: e = mk("[1Q", 38); 68: e = mk("[1R", 39);
      69: e = mk("[1S", 40);
      70: e = mk("OP", 37); 71: e = mk("OQ", 38); 72: e = mk("OR", 39); 73: e = mk("OS", 40);
      74: e = mk("[11;2~", 49); 75: e = mk("[12;2~", 50); 76: e = mk("[13;2~", 51);
      77: e = mk("[14;2~", 52); 78: e = mk("[15;2~", 53); 79: e = mk("[17;2~", 54);
      80: e = mk("[18;2~", 55); 81: e = mk("[19;2~", 56); 82: e = mk("[20;2~", 57);
      83: e = mk("[21;2~", 58); 84: e = mk("[23;2~", 59); 85: e = mk("[24;2~", 60);
      86: e = mk("[1;2P", 49); 87: e = mk("[1;2Q", 50); 88: e = mk("[1;2R", 51);
      89: e = mk("[1;2S", 52);
      90: e = mk("[11;3~", 61); 91: e = mk("[12;3~", 62); 92: e = mk("[13;3~", 63);
      93: e = mk("[14;3~", 64); 94: e = mk("[15;3~", 65); 95: e = mk("[17;3~", 66);
      96: e = mk("[18;3~", 67); 97: e = mk("[19;3~", 68); 98: e = mk("[20;3~", 69);
      99: e = mk("[21;3~", 70); 100: e = mk("[23;3~", 71); 101: e = mk("[24;3~", 72);
      102: e = mk("[1;3P", 61); 103: e = mk("[1;3Q", 62); 104: e = mk("[1;3R", 63);
      105: e = mk("[1;3S", 64);
      106: e = mk("[11;5~", 73); 107: e = mk("[12;5~", 74); 108: e = mk("[13;5~", 75);
      109: e = mk("[14;5~", 76); 110: e = mk("[15;5~", 77); 111: e = mk("[17;5~", 78);
      112: e = mk("[18;5~", 79); 113: e = mk("[19;5~", 80); 114: e = mk("[20;5~", 81);
      115: e = mk("[21;5~", 82); 116: e = mk("[23;5~", 83); 117: e = mk("[24;5~", 84);
      118: e = mk("[1;5P", 73); 119: e = mk("[1;5Q", 74); 120: e = mk("[1;5R", 75);
      121: e = mk("[1;5S", 76);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

[rtl/tekd_front.sv]
// front part: sequence tracking, byte buffering and item classification
`timescale 1ns / 1ps
module tekd_front #(
  parameter int SEQ_MAX_LEN = tekd_pkg::SeqMaxLenDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tekd_pkg::in_item_t in_data,
  input  logic [15:0]       timeout_limit,
  input  logic              function_keys_on,
  output logic              job_valid,
  input  logic              job_ready,
  output tekd_pkg::job_t    job
);

  localparam int LenW = $clog2(SEQ_MAX_LEN + 1);
  localparam int IdxW = $clog2(SEQ_MAX_LEN);

  logic            in_seq_r, in_seq_nxt;
  logic [16:0]     ticks_r, ticks_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [7:0]      buf_r [SEQ_MAX_LEN];
  logic            wr_en;
  logic [16:0]     ticks_inc;
  logic            final_byte;
  logic [7:0]      c;

  assign in_ready = job_ready;
  assign c = in_data.rx_byte;
  assign final_byte = (c >= "A" && c <= "H") || (c >= "P" && c <= "Z") ||
                      (c >= "a" && c <= "z") || c == "~";
  assign ticks_inc = (ticks_r < tekd_pkg::TickMax) ? ticks_r + 17'd1 : ticks_r;

  // classify the item and compute next sequence state
  always_comb begin
    in_seq_nxt = in_seq_r;
    ticks_nxt = ticks_r;
    len_nxt = len_r;
    wr_en = 1'b0;
    job = '0;
    job.status = tekd_pkg::StNothing;
    job.fkeys = function_keys_on;
    if (in_data.command == tekd_pkg::CmdTick) begin
      if (in_seq_r) begin
        ticks_nxt = ticks_inc;
        if (ticks_inc > {1'b0, timeout_limit}) begin
          in_seq_nxt = 1'b0;
          job.status = tekd_pkg::StBareEsc;
        end
      end
    end else if (c == tekd_pkg::EscByte) begin
      in_seq_nxt = 1'b1;
      ticks_nxt = '0;
      len_nxt = '0;
      job.status = tekd_pkg::StPending;
    end else if (in_seq_r) begin
      job.status = tekd_pkg::StPending;
      if (len_r < LenW'(SEQ_MAX_LEN)) begin
        wr_en = 1'b1;
        len_nxt = len_r + LenW'(1);
      end
      if (final_byte) begin
        in_seq_nxt = 1'b0;
        job.do_match = 1'b1;
        job.status = tekd_pkg::StUnknown;
      end
    end else begin
      job.status = tekd_pkg::StPlain;
      job.char_out = c;
    end
    // snapshot of the buffer including the byte written now
    job.len = (len_nxt > LenW'(tekd_pkg::EntryLen)) ? 4'hf : 4'(len_nxt);
    for (int i = 0; i < tekd_pkg::EntryLen; i++) begin
      job.bytes[8*i +: 8] = (wr_en && len_r == LenW'(i)) ? c : buf_r[i];
    end
  end

  assign job_valid = in_valid;

  // sequence state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_seq_r <= 1'b0;
      ticks_r <= '0;
      len_r <= '0;
    end else if (in_valid && in_ready) begin
      in_seq_r <= in_seq_nxt;
      ticks_r <= ticks_nxt;
      len_r <= len_nxt;
    end
  end

  // byte buffer, written at the current length
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && wr_en) buf_r[len_r[IdxW-1:0]] <= c;
  end

endmodule

[rtl/tekd_queue.sv]
// two-entry queue between the front and back parts
`timescale 1ns / 1ps
module tekd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  tekd_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output tekd_pkg::job_t rd_data
);

  tekd_pkg::job_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

[rtl/tekd_back.sv]
// back part: table match and result register
`timescale 1ns / 1ps
module tekd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  tekd_pkg::job_t     job,
  output logic               out_valid,
  input  logic               out_ready,
  output tekd_pkg::out_item_t out_data
);

  logic                valid_r;
  tekd_pkg::out_item_t res_r, res_nxt;
  tekd_pkg::entry_t    e;
  logic                hit;
  logic [6:0]          key;
  logic [7:0]          n;

  // parallel compare, first table hit wins
  always_comb begin
    hit = 1'b0;
    key = '0;
    e = '0;
    n = job.fkeys ? 8'(tekd_pkg::TableSize) : 8'(tekd_pkg::BaseEntries);
    for (int i = tekd_pkg::TableSize - 1; i >= 0; i--) begin
      e = tekd_pkg::table_row(i);
      if (8'(i) < n && e.len == job.len &&
          (job.bytes & ((48'h1 << (8 * e.len)) - 48'h1)) == e.text) begin
        hit = 1'b1;
        key = e.key;
      end
    end
    res_nxt.status = job.status;
    res_nxt.char_out = job.char_out;
    res_nxt.key_code = '0;
    if (job.do_match && hit) begin
      res_nxt.status = tekd_pkg::StKey;
      res_nxt.key_code = key;
    end
  end

  assign job_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data = res_r;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (job_ready) valid_r <= job_valid;
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) res_r <= res_nxt;
  end

endmodule

[rtl/terminal_escape_key_decoder.sv]
// Terminal escape key decoder: one byte or idle tick per cycle in, one result
// per item out; throughput is one item per cycle while the output is not
// stalled. Each result is registered in a queue entry and then in the output
// register. The front part tracks the sequence and buffers bytes, the back
// part matches the buffer against the key table in one parallel compare.
// Registers: 0x0 timeout_limit, 0x4 function_keys_on.
`timescale 1ns / 1ps
module terminal_escape_key_decoder #(
  parameter int SEQ_MAX_LEN = tekd_pkg::SeqMaxLenDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tekd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tekd_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [15:0]    timeout_r;
  logic           fkeys_r;
  logic           fq_valid, fq_ready, qb_valid, qb_ready;
  tekd_pkg::job_t fq_job, qb_job;

  // configuration registers
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= tekd_pkg::TimeoutReset;
      fkeys_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      if (cfg_paddr[2] == tekd_pkg::RegTimeout) timeout_r <= cfg_pwdata[15:0];
      else fkeys_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == tekd_pkg::RegFkeys) cfg_prdata[0] = fkeys_r;
    else cfg_prdata[15:0] = timeout_r;
  end

  tekd_front #(.SEQ_MAX_LEN(SEQ_MAX_LEN)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .timeout_limit(timeout_r), .function_keys_on(fkeys_r),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  tekd_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
  );

  tekd_back u_back (
    .clk, .rst_n, .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .out_valid, .out_ready, .out_data
  );

endmodule

[rtl/tekd_checker.sv]
// port-level checker bound to the decoder top level
`timescale 1ns / 1ps
module tekd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input tekd_pkg::out_item_t out_data,
  input logic                cfg_pready
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // char_out only with plain byte
  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != tekd_pkg::StPlain |-> out_data.char_out == 8'd0)
    else $error("char_out set for non-plain status");

  // key code only when decoded
  a_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != tekd_pkg::StKey |-> out_data.key_code == 7'd0)
    else $error("key_code set without decode");

  // status range and pready
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= tekd_pkg::StNothing && cfg_pready)
    else $error("bad status");

endmodule

bind terminal_escape_key_decoder tekd_checker u_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_data, .cfg_pready
);

[bench/terminal_escape_key_decoder_checker.sv]
// checker: predicts each result of the escape key decoder and compares it
`timescale 1ns / 1ps
module terminal_escape_key_decoder_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  tekd_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  tekd_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output int                  fail_count,
  output int                  pending_count,
  output int                  key_count
);

  localparam int BufLen = tekd_pkg::SeqMaxLenDefault;

  // predictor copy of the decoder state and registers
  logic [15:0]         timeout_lim;
  logic                fkeys_on;
  logic                seq_open;
  logic [16:0]         ticks;
  int                  seq_len;
  logic [7:0]          seq_buf [BufLen];
  tekd_pkg::out_item_t expected_results [$];

  function automatic logic final_byte(input logic [7:0] c);
    return (c >= "A" && c <= "H") || (c >= "P" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == "~";
  endfunction

  // sequence table lookup on the current buffer
  function automatic logic lookup_key(output logic [6:0] key);
    tekd_pkg::entry_t e;
    int               lim;
    logic             same;
    lim = fkeys_on ? tekd_pkg::TableSize : tekd_pkg::BaseEntries;
    key = '0;
    for (int i = 0; i < lim; i++) begin
      e = tekd_pkg::table_row(i);
      if (e.len != 0 && int'(e.len) == seq_len) begin
        same = 1'b1;
        for (int j = 0; j < seq_len; j++)
          if (e.text[8*j +: 8] != seq_buf[j]) same = 1'b0;
        if (same) begin
          key = e.key;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic tekd_pkg::out_item_t decode_step(input tekd_pkg::in_item_t it);
    tekd_pkg::out_item_t r;
    logic [6:0]          k;
    r = '0;
    r.status = tekd_pkg::StNothing;
    if (it.command == tekd_pkg::CmdTick) begin
      if (seq_open) begin
        if (ticks != tekd_pkg::TickMax) ticks = ticks + 17'd1;
        if (ticks > {1'b0, timeout_lim}) begin
          seq_open = 1'b0;
          r.status = tekd_pkg::StBareEsc;
        end
      end
    end else if (it.rx_byte == tekd_pkg::EscByte) begin
      seq_open = 1'b1;
      ticks = '0;
      seq_len = 0;
      r.status = tekd_pkg::StPending;
    end else if (seq_open) begin
      if (seq_len < BufLen) begin
        seq_buf[seq_len] = it.rx_byte;
        seq_len++;
      end
      r.status = tekd_pkg::StPending;
      if (final_byte(it.rx_byte)) begin
        seq_open = 1'b0;
        if (lookup_key(k)) begin
          r.status = tekd_pkg::StKey;
          r.key_code = k;
        end else r.status = tekd_pkg::StUnknown;
      end
    end else begin
      r.status = tekd_pkg::StPlain;
      r.char_out = it.rx_byte;
    end
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // watch the channels and the register port
  always @(posedge clk) begin
    tekd_pkg::out_item_t want;
    if (!rst_n) begin
      timeout_lim <= tekd_pkg::TimeoutReset;
      fkeys_on <= 1'b1;
      seq_open = 1'b0;
      ticks = '0;
      seq_len = 0;
      fail_count <= 0;
      key_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == tekd_pkg::RegFkeys) fkeys_on <= cfg_pwdata[0];
        else timeout_lim <= cfg_pwdata[15:0];
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", out_data);
        end else begin
          want = expected_results.pop_front();
          if (want.status == tekd_pkg::StKey) key_count <= key_count + 1;
          if (want.status != out_data.status || want.char_out != out_data.char_out ||
              want.key_code != out_data.key_code) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected st=%0d ch=%h key=%0d got st=%0d ch=%h key=%0d",
                       want.status, want.char_out, want.key_code,
                       out_data.status, out_data.char_out, out_data.key_code);
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(decode_step(in_data));
    end
  end
endmodule

[bench/terminal_escape_key_decoder_test.sv]
// testbench top: stimulus, register phases and verdict for the escape key decoder
`timescale 1ns / 1ps
module terminal_escape_key_decoder_test;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tekd_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tekd_pkg::out_item_t out_data;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [2:0]          cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;
  int                  fail_count;
  int                  pending_count;
  int                  key_count;
  int                  cycle_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  hold_cycles = 0;
  int                  item_total = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  terminal_escape_key_decoder u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  terminal_escape_key_decoder_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .fail_count, .pending_count, .key_count
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input transfer, with random idle before it; valid stays up after it
  task automatic send_item(input logic cmd, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{command: cmd, rx_byte: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_total++;
  endtask

  task automatic send_text(input string s);
    send_item(tekd_pkg::CmdByte, tekd_pkg::EscByte);
    for (int i = 0; i < s.len(); i++) send_item(tekd_pkg::CmdByte, s[i]);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic idx, input logic [31:0] v);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // random escape sequence, mostly from the key table
  task automatic send_random_seq();
    tekd_pkg::entry_t e;
    int               n;
    e = tekd_pkg::table_row($urandom_range(tekd_pkg::TableSize - 1));
    if ($urandom_range(3) != 0) begin
      send_item(tekd_pkg::CmdByte, tekd_pkg::EscByte);
      for (int i = 0; i < int'(e.len); i++) begin
        if ($urandom_range(30) == 0) send_item(tekd_pkg::CmdTick, 8'($urandom));
        send_item(tekd_pkg::CmdByte, e.text[8*i +: 8]);
      end
    end else begin
      send_item(tekd_pkg::CmdByte, tekd_pkg::EscByte);
      n = $urandom_range(11);
      for (int i = 0; i < n; i++) send_item(tekd_pkg::CmdByte, 8'($urandom));
      send_item(tekd_pkg::CmdByte,
                ($urandom_range(1) != 0) ? 8'h7e : 8'($urandom_range(65, 72)));
    end
  endtask

  task automatic random_phase(input int n, input int idle, input int stall);
    int stop_at;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    stop_at = item_total + n;
    while (item_total < stop_at) begin
      case ($urandom_range(9))
        0, 1: send_item(tekd_pkg::CmdByte, 8'($urandom));
        2: send_item(tekd_pkg::CmdTick, 8'($urandom));
        3: repeat ($urandom_range(12)) send_item(tekd_pkg::CmdTick, 8'($urandom));
        default: send_random_seq();
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: plain bytes, several kinds of key, special cases
    send_item(tekd_pkg::CmdByte, 8'h00);
    send_item(tekd_pkg::CmdByte, 8'hff);
    send_item(tekd_pkg::CmdTick, 8'hff);
    send_text("[A");
    send_text("[1;5A");
    send_text("OA");
    send_text("[11;2~");
    send_item(tekd_pkg::CmdByte, tekd_pkg::EscByte);
    send_text("[00000000000~");
    send_item(tekd_pkg::CmdByte, tekd_pkg::EscByte);
    send_item(tekd_pkg::CmdByte, 8'h00);
    send_item(tekd_pkg::CmdByte, "A");
    write_reg(tekd_pkg::RegFkeys, 32'd0);
    send_text("[11;2~");
    write_reg(tekd_pkg::RegTimeout, 32'd0);
    send_item(tekd_pkg::CmdByte, tekd_pkg::EscByte);
    send_item(tekd_pkg::CmdTick, 8'h00);
    write_reg(tekd_pkg::RegTimeout, 32'd3);
    send_item(tekd_pkg::CmdByte, tekd_pkg::EscByte);
    repeat (5) send_item(tekd_pkg::CmdTick, 8'h00);
    write_reg(tekd_pkg::RegTimeout, 32'hffff);
    write_reg(tekd_pkg::RegFkeys, 32'd1);

    random_phase(200, 0, 0);
    random_phase(200, 49, 0);
    write_reg(tekd_pkg::RegTimeout, 32'd5);
    random_phase(200, 0, 49);
    write_reg(tekd_pkg::RegFkeys, 32'd0);
    random_phase(150, 25, 25);
    write_reg(tekd_pkg::RegFkeys, 32'd1);
    write_reg(tekd_pkg::RegTimeout, 32'd1);
    // long receiver hold-off while items keep coming
    hold_cycles = 60;
    random_phase(100, 0, 0);
    write_reg(tekd_pkg::RegTimeout, 32'd100);
    random_phase(250, 25, 25);

    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("%0d items sent over all idle and stall phases, %0d keys decoded",
             item_total, key_count);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

[terminal_escape_key_decoder.f]
rtl/tekd_pkg.sv
rtl/tekd_front.sv
rtl/tekd_queue.sv
rtl/tekd_back.sv
rtl/terminal_escape_key_decoder.sv
rtl/tekd_checker.sv
bench/terminal_escape_key_decoder_checker.sv
bench/terminal_escape_key_decoder_test.sv
